@@ rtl/i2c_master_transaction_sequencer_unit_assert.svh @@
// Assertion macros for the I2C master transaction sequencer checker.
// Used by the bound checker module only.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Property checked on the rising clock edge, ignored while reset is high.
`define I2CMS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define I2CMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/i2cms_pkg.sv @@
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies.
package i2cms_pkg;

   localparam int BUF_DEPTH_DEF = 32;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_READY = 3'd0,
      PH_MTRX  = 3'd1,
      PH_MRX   = 3'd2,
      PH_MTX   = 3'd3,
      PH_RMW   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_ACK     = 3'd2,
      CMD_NACK    = 3'd3,
      CMD_STOP    = 3'd4,
      CMD_RESTART = 3'd5,
      CMD_RELEASE = 3'd6
   } cmd_type;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ADDR_NACK = 3'd1;
   localparam logic [2:0] ERR_DATA_NACK = 3'd2;
   localparam logic [2:0] ERR_ARB_LOST  = 3'd3;
   localparam logic [2:0] ERR_BUS       = 3'd4;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RMW   = 2'd2;

   // two-wire controller status codes, prescaler bits cleared
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] ST_BUS_ERR      = 8'h00;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_RESTART      = 8'h10;
   localparam logic [7:0] ST_TX_ADDR_ACK  = 8'h18;
   localparam logic [7:0] ST_TX_ADDR_NACK = 8'h20;
   localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_TX_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST     = 8'h38;
   localparam logic [7:0] ST_RX_ADDR_ACK  = 8'h40;
   localparam logic [7:0] ST_RX_ADDR_NACK = 8'h48;
   localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
   localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  status_code;
      logic [7:0]  rx_byte;
      logic [4:0]  buf_index;
      logic [7:0]  data_byte;
      logic [7:0]  keep_mask;
      logic [1:0]  mode;
      logic [6:0]  target_addr;
      logic [1:0]  reg_count;
      logic [15:0] reg_address;
      logic [5:0]  length;
   } req_type;

   typedef struct packed {
      cmd_type    bus_command;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       busy_res;
      logic       accepted;
      logic [2:0] error_code;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      logic data_we;
      logic mask_we;
   } mem_wr_type;

endpackage

@@ rtl/i2c_master_transaction_sequencer_unit.sv @@
// I2C master transaction sequencer, top level.
// An accepted request is registered, then the execute step writes the response.
// Throughput: one request per cycle unless a response is stalled; the buffer read
// is issued at accept, and forwarding covers same-entry writes.
// Reset (synchronous, active high) returns the sequencer to ready; buffer
// contents are undefined until loaded.
module i2c_master_transaction_sequencer_unit #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_status_code,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  req_buf_index,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_keep_mask,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_target_addr,
   input  logic [1:0]  req_reg_count,
   input  logic [15:0] req_reg_address,
   input  logic [5:0]  req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bus_command,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_busy_res,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_error_code,
   output logic [7:0]  rsp_read_byte
);
   import i2cms_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   req_type    req_in;
   req_type    s1_req_ff;
   logic       s1_valid_ff, s1_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       exec_en;
   mem_wr_type wr_ctl;
   logic [AW-1:0] wr_addr;
   logic [7:0] wr_data;
   logic [7:0] wr_mask;
   logic [AW-1:0] rd_addr;
   logic [7:0] mem_data;
   logic [7:0] mem_mask;
   logic [5:0] pos_next;

   assign req_in.opcode      = opcode_type'(req_opcode);
   assign req_in.status_code = req_status_code;
   assign req_in.rx_byte     = req_rx_byte;
   assign req_in.buf_index   = req_buf_index;
   assign req_in.data_byte   = req_data_byte;
   assign req_in.keep_mask   = req_keep_mask;
   assign req_in.mode        = req_mode;
   assign req_in.target_addr = req_target_addr;
   assign req_in.reg_count   = req_reg_count;
   assign req_in.reg_address = req_reg_address;
   assign req_in.length      = req_length;

   assign exec_en   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || exec_en;
   assign accept    = req_valid && req_ready;

   // events address the buffer at the byte position left by the request ahead
   assign rd_addr = (req_in.opcode == OP_EVENT) ? AW'(pos_next) : AW'(req_buf_index);

   assign s1_valid_in  = accept ? 1'b1 : (exec_en ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = exec_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_in;
      end
      if (exec_en) begin
         rsp_ff <= rsp_in;
      end
   end

   i2cms_buf #(
      .BUF_DEPTH (BUF_DEPTH),
      .AW        (AW)
   ) u_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (mem_data),
      .rd_mask (mem_mask)
   );

   i2cms_seq #(
      .BUF_DEPTH (BUF_DEPTH),
      .AW        (AW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .exec_en  (exec_en),
      .req      (s1_req_ff),
      .mem_data (mem_data),
      .mem_mask (mem_mask),
      .rsp      (rsp_in),
      .wr_ctl   (wr_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .wr_mask  (wr_mask),
      .pos_next (pos_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bus_command = rsp_ff.bus_command;
   assign rsp_tx_valid    = rsp_ff.tx_valid;
   assign rsp_tx_byte     = rsp_ff.tx_byte;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_error_code  = rsp_ff.error_code;
   assign rsp_read_byte   = rsp_ff.read_byte;

endmodule

@@ rtl/i2cms_buf.sv @@
// Data and mask buffer memories: one write port, one registered read port,
// with forwarding of a write that lands on the edge of the read. Uses i2cms_pkg.
module i2cms_buf #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
   parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cms_pkg::mem_wr_type  wr_ctl,
   input  logic [AW-1:0]          wr_addr,
   input  logic [7:0]             wr_data,
   input  logic [7:0]             wr_mask,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [7:0]             rd_data,
   output logic [7:0]             rd_mask
);
   import i2cms_pkg::*;

   logic [7:0] data_mem [BUF_DEPTH];
   logic [7:0] mask_mem [BUF_DEPTH];

   logic [7:0] data_q_ff;
   logic [7:0] mask_q_ff;
   logic [7:0] fwd_data_ff;
   logic [7:0] fwd_mask_ff;
   logic       hit_data_ff;
   logic       hit_mask_ff;
   logic       hit_data_in;
   logic       hit_mask_in;

   always_ff @(posedge clock) begin
      if (wr_ctl.data_we) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (wr_ctl.mask_we) begin
         mask_mem[wr_addr] <= wr_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_q_ff   <= data_mem[rd_addr];
         mask_q_ff   <= mask_mem[rd_addr];
         fwd_data_ff <= wr_data;
         fwd_mask_ff <= wr_mask;
      end
   end

   // a write on the read edge is not seen by the array read
   assign hit_data_in = rd_en ? (wr_ctl.data_we && (wr_addr == rd_addr)) : hit_data_ff;
   assign hit_mask_in = rd_en ? (wr_ctl.mask_we && (wr_addr == rd_addr)) : hit_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_data_ff <= 1'b0;
         hit_mask_ff <= 1'b0;
      end else begin
         hit_data_ff <= hit_data_in;
         hit_mask_ff <= hit_mask_in;
      end
   end

   assign rd_data = hit_data_ff ? fwd_data_ff : data_q_ff;
   assign rd_mask = hit_mask_ff ? fwd_mask_ff : mask_q_ff;

endmodule

@@ rtl/i2cms_seq.sv @@
// Transaction sequencer control: phase and counters, per-request execute step,
// buffer write-back. Uses i2cms_pkg.
module i2cms_seq #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
   parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   exec_en,
   input  i2cms_pkg::req_type     req,
   input  logic [7:0]             mem_data,
   input  logic [7:0]             mem_mask,
   output i2cms_pkg::rsp_type     rsp,
   output i2cms_pkg::mem_wr_type  wr_ctl,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_data,
   output logic [7:0]             wr_mask,
   output logic [5:0]             pos_next
);
   import i2cms_pkg::*;

   phase_type   phase_ff,      phase_in;
   logic [7:0]  addr_rw_ff,    addr_rw_in;
   logic [1:0]  reg_total_ff,  reg_total_in;
   logic [1:0]  reg_sent_ff,   reg_sent_in;
   logic [15:0] reg_addr_ff,   reg_addr_in;
   logic [5:0]  byte_pos_ff,   byte_pos_in;
   logic [5:0]  byte_limit_ff, byte_limit_in;
   logic [2:0]  last_err_ff,   last_err_in;

   logic [7:0]  status;
   logic [7:0]  merged;
   logic        pos_ok;
   logic        bidx_ok;
   logic [5:0]  len;
   logic [1:0]  rc;
   mem_wr_type  wr_raw;

   always_comb begin
      phase_in      = phase_ff;
      addr_rw_in    = addr_rw_ff;
      reg_total_in  = reg_total_ff;
      reg_sent_in   = reg_sent_ff;
      reg_addr_in   = reg_addr_ff;
      byte_pos_in   = byte_pos_ff;
      byte_limit_in = byte_limit_ff;
      last_err_in   = last_err_ff;

      status  = req.status_code & STATUS_MASK;
      merged  = (mem_data & mem_mask) | (req.rx_byte & ~mem_mask);
      pos_ok  = int'(byte_pos_ff) < BUF_DEPTH;
      bidx_ok = int'(req.buf_index) < BUF_DEPTH;
      len     = req.length;
      rc      = (req.reg_count == 2'd3) ? 2'd2 : req.reg_count;

      wr_raw  = '0;
      wr_addr = AW'(byte_pos_ff);
      wr_data = req.rx_byte;
      wr_mask = req.keep_mask;

      rsp             = '0;
      rsp.bus_command = CMD_NONE;
      rsp.accepted    = 1'b1;

      case (req.opcode)
         OP_LOAD: begin
            if (bidx_ok) begin
               wr_raw.data_we = 1'b1;
               wr_raw.mask_we = 1'b1;
               wr_addr        = AW'(req.buf_index);
               wr_data        = req.data_byte;
            end
         end
         OP_READ: begin
            if (bidx_ok) begin
               rsp.read_byte = mem_data;
            end
         end
         OP_START: begin
            if (phase_ff != PH_READY) begin
               rsp.accepted = 1'b0;
            end else begin
               if (int'(len) > BUF_DEPTH) begin
                  len = 6'(BUF_DEPTH);
               end
               if (req.mode != MODE_WRITE && len == 6'd0) begin
                  len = 6'd1;
               end
               reg_total_in = rc;
               reg_sent_in  = 2'd0;
               reg_addr_in  = req.reg_address;
               byte_pos_in  = 6'd0;
               last_err_in  = ERR_NONE;
               if (req.mode == MODE_WRITE) begin
                  phase_in      = PH_MTX;
                  byte_limit_in = len;
                  addr_rw_in    = {req.target_addr, 1'b0};
               end else begin
                  // mode three runs as a plain read
                  phase_in      = (req.mode == MODE_RMW) ? PH_RMW :
                                  ((rc != 2'd0) ? PH_MTRX : PH_MRX);
                  byte_limit_in = len - 6'd1;
                  addr_rw_in    = {req.target_addr, (rc == 2'd0)};
               end
               rsp.bus_command = CMD_START;
            end
         end
         OP_EVENT: begin
            if (phase_ff != PH_READY) begin
               case (status)
                  ST_START, ST_RESTART: begin
                     rsp.tx_byte     = addr_rw_ff;
                     rsp.tx_valid    = 1'b1;
                     rsp.bus_command = CMD_ACK;
                  end
                  ST_TX_ADDR_ACK, ST_TX_DATA_ACK: begin
                     if (reg_sent_ff < reg_total_ff) begin
                        rsp.tx_byte = (reg_total_ff == 2'd2 && reg_sent_ff == 2'd0) ?
                                      reg_addr_ff[15:8] : reg_addr_ff[7:0];
                        rsp.tx_valid    = 1'b1;
                        rsp.bus_command = CMD_ACK;
                        reg_sent_in     = reg_sent_ff + 2'd1;
                     end else if (phase_ff == PH_MTRX || phase_ff == PH_RMW) begin
                        addr_rw_in      = addr_rw_ff | 8'h01;
                        rsp.bus_command = CMD_RESTART;
                     end else if (byte_pos_ff < byte_limit_ff) begin
                        rsp.tx_byte     = pos_ok ? mem_data : 8'h00;
                        rsp.tx_valid    = 1'b1;
                        rsp.bus_command = CMD_ACK;
                        byte_pos_in     = byte_pos_ff + 6'd1;
                     end else begin
                        phase_in        = PH_READY;
                        rsp.bus_command = CMD_STOP;
                     end
                  end
                  ST_TX_ADDR_NACK: begin
                     last_err_in     = ERR_ADDR_NACK;
                     phase_in        = PH_READY;
                     rsp.bus_command = CMD_STOP;
                  end
                  ST_TX_DATA_NACK: begin
                     last_err_in     = ERR_DATA_NACK;
                     phase_in        = PH_READY;
                     rsp.bus_command = CMD_STOP;
                  end
                  ST_ARB_LOST: begin
                     last_err_in     = ERR_ARB_LOST;
                     phase_in        = PH_READY;
                     rsp.bus_command = CMD_RELEASE;
                  end
                  ST_RX_DATA_ACK: begin
                     wr_raw.data_we  = pos_ok;
                     wr_data         = (phase_ff == PH_RMW) ? merged : req.rx_byte;
                     byte_pos_in     = byte_pos_ff + 6'd1;
                     rsp.bus_command = (byte_pos_in < byte_limit_ff) ? CMD_ACK : CMD_NACK;
                  end
                  ST_RX_ADDR_ACK: begin
                     rsp.bus_command = (byte_pos_ff < byte_limit_ff) ? CMD_ACK : CMD_NACK;
                  end
                  ST_RX_DATA_NACK: begin
                     wr_raw.data_we = pos_ok;
                     if (phase_ff == PH_RMW) begin
                        // last byte read back: turn around and write the merged buffer
                        wr_data         = merged;
                        byte_pos_in     = 6'd0;
                        byte_limit_in   = byte_limit_ff + 6'd1;
                        reg_sent_in     = 2'd0;
                        phase_in        = PH_MTX;
                        addr_rw_in      = addr_rw_ff & 8'hFE;
                        rsp.bus_command = CMD_RESTART;
                     end else begin
                        wr_data         = req.rx_byte;
                        byte_pos_in     = byte_pos_ff + 6'd1;
                        phase_in        = PH_READY;
                        rsp.bus_command = CMD_STOP;
                     end
                  end
                  ST_RX_ADDR_NACK: begin
                     phase_in        = PH_READY;
                     rsp.bus_command = CMD_STOP;
                  end
                  ST_BUS_ERR: begin
                     last_err_in     = ERR_BUS;
                     phase_in        = PH_READY;
                     rsp.bus_command = CMD_STOP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      rsp.busy_res   = (phase_in != PH_READY);
      rsp.error_code = last_err_in;
   end

   assign wr_ctl.data_we = wr_raw.data_we && exec_en;
   assign wr_ctl.mask_we = wr_raw.mask_we && exec_en;
   assign pos_next       = exec_en ? byte_pos_in : byte_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_READY;
         addr_rw_ff    <= 8'h00;
         reg_total_ff  <= 2'd0;
         reg_sent_ff   <= 2'd0;
         reg_addr_ff   <= 16'h0000;
         byte_pos_ff   <= 6'd0;
         byte_limit_ff <= 6'd0;
         last_err_ff   <= ERR_NONE;
      end else if (exec_en) begin
         phase_ff      <= phase_in;
         addr_rw_ff    <= addr_rw_in;
         reg_total_ff  <= reg_total_in;
         reg_sent_ff   <= reg_sent_in;
         reg_addr_ff   <= reg_addr_in;
         byte_pos_ff   <= byte_pos_in;
         byte_limit_ff <= byte_limit_in;
         last_err_ff   <= last_err_in;
      end
   end

endmodule

@@ rtl/i2cms_checker.sv @@
// Port-level checker for the I2C master transaction sequencer, bound to the top.
// Uses i2cms_pkg and the assertion macro header.
`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2cms_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_bus_command,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_busy_res,
   input logic        rsp_accepted
);
   import i2cms_pkg::*;

   `I2CMS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `I2CMS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_tx_byte) && $stable(rsp_bus_command), "stalled response changed")
   `I2CMS_ASSERT(a_tx_cmd, clock, reset, rsp_valid && rsp_tx_valid |-> rsp_bus_command == CMD_ACK && rsp_busy_res, "transmit byte without continue ack")
   `I2CMS_ASSERT(a_refused, clock, reset, rsp_valid && !rsp_accepted |-> rsp_bus_command == CMD_NONE && rsp_busy_res && !rsp_tx_valid, "refused start with bus activity")
   `I2CMS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_i2cms_checker (.*);
